// ----- rtl/matrix_inverse_4x4_defines.svh -----
// Assertion macros shared by the matrix inverse checker.
`ifndef MATRIX_INVERSE_4X4_DEFINES_SVH
`define MATRIX_INVERSE_4X4_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define MI4_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define MI4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mi4_pkg.sv -----
// Types, constants and term tables for the 4x4 matrix inverse.
package mi4_pkg;

  localparam int ELEM_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int QBITS      = 2 * FRAC_BITS + 1;
  localparam int CNT_W      = $clog2(QBITS + 1);
  localparam int ACC_W      = 136;
  localparam int PROD_W     = 66;
  localparam int OPA_W      = 33;
  localparam int IDX_W      = 4;
  localparam int BADDR_W    = 5;
  localparam int NUM_ELEMS  = 16;
  localparam int BDEPTH     = 32;
  localparam int COF_BASE   = 16;
  localparam int LAST_INDEX = 15;

  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef logic signed [ACC_W-1:0] acc_t;

  // Work phases: 2x2 minors, cofactors, determinant, quotients
  typedef enum logic [1:0] {PH_MINOR2, PH_COF, PH_DET, PH_QUOT} phase_t;

  // One product term: element times element or stored wide value
  typedef struct packed {
    logic [IDX_W-1:0]   ea;
    logic [IDX_W-1:0]   eb;
    logic [BADDR_W-1:0] baddr;
    logic               neg;
  } term_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic             done;
    logic             over;
    logic [QBITS-1:0] quot;
  } div_res_t;

  // Column pair {i, j} of 2x2 minor m
  function automatic logic [3:0] pair_f(logic [2:0] m);
    logic [3:0] p;
    case (m)
      3'd0:    p = {2'd0, 2'd1};
      3'd1:    p = {2'd0, 2'd2};
      3'd2:    p = {2'd0, 2'd3};
      3'd3:    p = {2'd1, 2'd2};
      3'd4:    p = {2'd1, 2'd3};
      3'd5:    p = {2'd2, 2'd3};
      default: p = '0;
    endcase
    return p;
  endfunction

  // Minor used by term j of a cofactor in inverse row r
  function automatic logic [2:0] cof_pair_f(logic [1:0] r, logic [1:0] j);
    logic [2:0] p;
    case ({r, j})
      4'd0:    p = 3'd5;
      4'd1:    p = 3'd4;
      4'd2:    p = 3'd3;
      4'd4:    p = 3'd5;
      4'd5:    p = 3'd2;
      4'd6:    p = 3'd1;
      4'd8:    p = 3'd4;
      4'd9:    p = 3'd2;
      4'd10:   p = 3'd0;
      4'd12:   p = 3'd3;
      4'd13:   p = 3'd1;
      4'd14:   p = 3'd0;
      default: p = '0;
    endcase
    return p;
  endfunction

  // Operands and sign of term j in group g of a phase
  function automatic term_t term_f(phase_t ph, logic [3:0] g, logic [1:0] j);
    term_t      t;
    logic [2:0] m;
    logic [3:0] pr;
    logic [1:0] r0;
    logic [1:0] r1;
    logic [1:0] rw;
    logic [1:0] cl;
    logic [2:0] pidx;
    t    = '0;
    m    = '0;
    pr   = '0;
    r0   = '0;
    r1   = '0;
    rw   = '0;
    cl   = '0;
    pidx = '0;
    case (ph)
      PH_MINOR2: begin
        r0 = (g < 4'd6) ? 2'd0 : 2'd2;
        r1 = r0 + 2'd1;
        m  = (g < 4'd6) ? g[2:0] : 3'(g - 4'd6);
        pr = pair_f(m);
        if (!j[0]) begin
          t.ea  = {r0, pr[3:2]};
          t.eb  = {r1, pr[1:0]};
          t.neg = 1'b0;
        end else begin
          t.ea  = {r1, pr[3:2]};
          t.eb  = {r0, pr[1:0]};
          t.neg = 1'b1;
        end
      end
      PH_COF: begin
        rw      = g[1:0] ^ 2'd1;
        cl      = (j >= g[3:2]) ? j + 2'd1 : j;
        pidx    = cof_pair_f(g[3:2], j);
        t.ea    = {rw, cl};
        t.baddr = (g[1:0] < 2'd2) ? BADDR_W'(pidx) + BADDR_W'(6) : BADDR_W'(pidx);
        t.neg   = j[0] ^ g[2] ^ g[0];
      end
      PH_DET: begin
        t.ea    = {2'd0, j};
        t.baddr = BADDR_W'(COF_BASE) + {1'b0, j, 2'b00};
      end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/mi4_if.sv -----
// Valid/ready channel interfaces for matrix elements and inverse results.
interface mi4_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [mi4_pkg::ELEM_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface mi4_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mi4_pkg::ELEM_W-1:0] inverse_value;
  logic [mi4_pkg::IDX_W-1:0]         element_index;
  logic                              singular;
  logic                              saturated;
  logic                              last_of_matrix;

  modport source (output valid, output inverse_value, output element_index,
                  output singular, output saturated, output last_of_matrix, input ready);
  modport sink   (input valid, input inverse_value, input element_index,
                  input singular, input saturated, input last_of_matrix, output ready);
endinterface

// ----- rtl/mi4_ram.sv -----
// Generic single-port-write RAM with one registered read port.
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mi4_div.sv -----
// Restoring divider: one quotient bit of |C| * 2^(2F) / |D| per cycle.
module mi4_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mi4_pkg::ACC_W-1:0] num,
  input  logic [mi4_pkg::ACC_W-1:0] den,
  output mi4_pkg::div_res_t         res
);

  logic                        busy_r;
  logic                        first_r;
  logic                        done_r;
  logic                        over_r;
  logic [mi4_pkg::CNT_W-1:0]   cnt_r;
  logic [mi4_pkg::ACC_W-1:0]   rem_r;
  logic [mi4_pkg::ACC_W-1:0]   den_r;
  logic [mi4_pkg::QBITS-1:0]   quot_r;
  logic [mi4_pkg::ACC_W-1:0]   trial;
  logic                        ge;

  // First step takes the top quotient bit without a shift
  assign trial = first_r ? rem_r : {rem_r[mi4_pkg::ACC_W-2:0], 1'b0};
  assign ge    = (trial >= den_r);

  assign res.done = done_r;
  assign res.over = over_r;
  assign res.quot = quot_r;

  // Load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= mi4_pkg::CNT_W'(mi4_pkg::QBITS);
        rem_r   <= num;
        den_r   <= den;
        over_r  <= ({1'b0, num} >= {den, 1'b0});
        quot_r  <= '0;
      end else if (busy_r) begin
        first_r <= 1'b0;
        rem_r   <= ge ? trial - den_r : trial;
        quot_r  <= {quot_r[mi4_pkg::QBITS-2:0], ge};
        cnt_r   <= cnt_r - 1'b1;
        if (cnt_r == mi4_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/matrix_inverse_4x4.sv -----
// 4x4 fixed-point matrix inverse by the adjugate, top level.
//
//   channel | dir | beat payload
//   in_ch   | in  | element_value (row-major Q16.16)
//   out_ch  | out | inverse_value, element_index, singular, saturated, last_of_matrix
//
// Element beats are taken one per cycle while the block is loading; a matrix
// then runs 24 minor terms, 48 cofactor terms and 4 determinant terms on
// the shared 33x33 multiplier, and each non-singular result goes through the
// bit-serial divider, which takes one quotient bit per cycle.
// Reset returns to loading with an empty load count; a stalled result beat
// holds the sequencer, and loading of the next matrix starts after the last.
module matrix_inverse_4x4 (
  input  logic       clk,
  input  logic       rst_n,
  mi4_in_if.sink     in_ch,
  mi4_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    S_LOAD, S_RD, S_LAT, S_LAT2, S_MUL, S_ACC, S_DRD, S_DLAT, S_DIV, S_PUT
  } state_t;

  state_t                                state_r;
  mi4_pkg::phase_t                       phase_r;
  logic [mi4_pkg::IDX_W-1:0]             load_cnt_r;
  logic [3:0]                            g_r;
  logic [1:0]                            j_r;
  logic [1:0]                            k_r;
  logic signed [mi4_pkg::OPA_W-1:0]      opa_r;
  mi4_pkg::acc_t                         opb_r;
  logic signed [mi4_pkg::PROD_W-1:0]     prod_r;
  mi4_pkg::acc_t                         acc_r;
  logic [mi4_pkg::ACC_W-1:0]             det_abs_r;
  logic                                  det_neg_r;
  logic                                  det_zero_r;
  logic                                  cneg_r;
  logic [mi4_pkg::ELEM_W-1:0]            res_value_r;
  logic                                  res_sing_r;
  logic                                  res_sat_r;
  logic                                  out_valid_r;
  logic [mi4_pkg::ELEM_W-1:0]            out_value_r;
  logic [mi4_pkg::IDX_W-1:0]             out_index_r;
  logic                                  out_sing_r;
  logic                                  out_sat_r;
  logic                                  out_last_r;

  logic                                  in_acc;
  logic [mi4_pkg::IDX_W-1:0]             a_raddr;
  logic [mi4_pkg::ELEM_W-1:0]            a_rdata;
  logic                                  b_we;
  logic [mi4_pkg::BADDR_W-1:0]           b_waddr;
  logic [mi4_pkg::BADDR_W-1:0]           b_raddr;
  logic [mi4_pkg::ACC_W-1:0]             b_rdata;
  mi4_pkg::term_t                        term;
  logic [1:0]                            nch_m1;
  logic [1:0]                            nterm_m1;
  logic [3:0]                            ngrp_m1;
  logic                                  last_chunk;
  logic                                  last_term;
  logic                                  last_grp;
  logic signed [mi4_pkg::OPA_W-1:0]      chunk;
  mi4_pkg::acc_t                         term_w;
  mi4_pkg::acc_t                         acc_nxt;
  logic                                  div_start;
  logic [mi4_pkg::ACC_W-1:0]             div_num;
  mi4_pkg::div_res_t                     div_res;
  logic                                  quot_neg;
  logic                                  quot_sat;
  logic [mi4_pkg::ELEM_W-1:0]            quot_value;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_LOAD);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.inverse_value  = out_value_r;
  assign out_ch.element_index  = out_index_r;
  assign out_ch.singular       = out_sing_r;
  assign out_ch.saturated      = out_sat_r;
  assign out_ch.last_of_matrix = out_last_r;

  // Look up the current product term
  assign term = mi4_pkg::term_f(phase_r, g_r, j_r);

  // Chunk counts, term counts and group counts per phase
  always_comb begin
    case (phase_r)
      mi4_pkg::PH_MINOR2: begin
        nch_m1 = 2'd0; nterm_m1 = 2'd1; ngrp_m1 = 4'd11;
      end
      mi4_pkg::PH_COF: begin
        nch_m1 = 2'd1; nterm_m1 = 2'd2; ngrp_m1 = 4'd15;
      end
      mi4_pkg::PH_DET: begin
        nch_m1 = 2'd2; nterm_m1 = 2'd3; ngrp_m1 = 4'd0;
      end
      default: begin
        nch_m1 = 2'd0; nterm_m1 = 2'd0; ngrp_m1 = 4'd0;
      end
    endcase
  end

  assign last_chunk = (k_r == nch_m1);
  assign last_term  = (j_r == nterm_m1);
  assign last_grp   = (g_r == ngrp_m1);

  // Pick a 32-bit slice of the wide operand, 33 bits for the signed top slice
  always_comb begin
    if (last_chunk) begin
      chunk = opb_r[{k_r, 5'b0} +: mi4_pkg::OPA_W];
    end else begin
      chunk = {1'b0, opb_r[{k_r, 5'b0} +: (mi4_pkg::OPA_W - 1)]};
    end
  end

  // Align the partial product and accumulate
  assign term_w  = {{(mi4_pkg::ACC_W - mi4_pkg::PROD_W){prod_r[mi4_pkg::PROD_W-1]}}, prod_r}
                   <<< {k_r, 5'b0};
  assign acc_nxt = term.neg ? acc_r - term_w : acc_r + term_w;

  // Matrix store
  assign a_raddr = (state_r == S_LAT) ? term.eb : term.ea;

  mi4_ram #(
    .WIDTH (mi4_pkg::ELEM_W),
    .DEPTH (mi4_pkg::NUM_ELEMS)
  ) u_mat_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (load_cnt_r),
    .wdata (in_ch.element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // Minor and cofactor store; each entry is written before it is read
  assign b_we    = (state_r == S_ACC) && last_chunk && last_term &&
                   (phase_r != mi4_pkg::PH_DET);
  assign b_waddr = (phase_r == mi4_pkg::PH_MINOR2) ? {1'b0, g_r}
                   : mi4_pkg::BADDR_W'(mi4_pkg::COF_BASE) + {1'b0, g_r};
  assign b_raddr = (state_r == S_DRD)
                   ? mi4_pkg::BADDR_W'(mi4_pkg::COF_BASE) + {1'b0, g_r}
                   : term.baddr;

  mi4_ram #(
    .WIDTH (mi4_pkg::ACC_W),
    .DEPTH (mi4_pkg::BDEPTH)
  ) u_wide_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (acc_nxt),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Divide cofactor magnitude by determinant magnitude
  assign div_start = (state_r == S_DLAT) && !det_zero_r;
  assign div_num   = b_rdata[mi4_pkg::ACC_W-1] ? -b_rdata : b_rdata;

  mi4_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (det_abs_r),
    .res   (div_res)
  );

  // Apply sign and clip to the element range
  always_comb begin
    quot_neg = cneg_r ^ det_neg_r;
    if (quot_neg) begin
      quot_sat   = div_res.over ||
                   (div_res.quot > mi4_pkg::QBITS'(mi4_pkg::ELEM_MIN));
      quot_value = quot_sat ? mi4_pkg::ELEM_MIN
                   : -div_res.quot[mi4_pkg::ELEM_W-1:0];
    end else begin
      quot_sat   = div_res.over ||
                   (div_res.quot > mi4_pkg::QBITS'(mi4_pkg::ELEM_MAX));
      quot_value = quot_sat ? mi4_pkg::ELEM_MAX : div_res.quot[mi4_pkg::ELEM_W-1:0];
    end
  end

  // Sequencer, datapath registers and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      phase_r     <= mi4_pkg::PH_MINOR2;
      load_cnt_r  <= '0;
      g_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop a taken beat unless a new one replaces it
      if (out_ch.valid && out_ch.ready && (state_r != S_PUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            load_cnt_r <= load_cnt_r + 1'b1;
            if (load_cnt_r == mi4_pkg::IDX_W'(mi4_pkg::LAST_INDEX)) begin
              phase_r <= mi4_pkg::PH_MINOR2;
              g_r     <= '0;
              j_r     <= '0;
              acc_r   <= '0;
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          state_r <= S_LAT;
        end
        S_LAT: begin
          opa_r <= {a_rdata[mi4_pkg::ELEM_W-1], a_rdata};
          k_r   <= '0;
          if (phase_r == mi4_pkg::PH_MINOR2) begin
            state_r <= S_LAT2;
          end else begin
            opb_r   <= b_rdata;
            state_r <= S_MUL;
          end
        end
        S_LAT2: begin
          opb_r   <= {{(mi4_pkg::ACC_W - mi4_pkg::ELEM_W){a_rdata[mi4_pkg::ELEM_W-1]}},
                      a_rdata};
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= opa_r * chunk;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (!last_chunk) begin
            acc_r   <= acc_nxt;
            k_r     <= k_r + 2'd1;
            state_r <= S_MUL;
          end else if (!last_term) begin
            acc_r   <= acc_nxt;
            j_r     <= j_r + 2'd1;
            state_r <= S_RD;
          end else begin
            acc_r <= '0;
            j_r   <= '0;
            if (phase_r == mi4_pkg::PH_DET) begin
              det_neg_r  <= acc_nxt[mi4_pkg::ACC_W-1];
              det_zero_r <= (acc_nxt == '0);
              det_abs_r  <= acc_nxt;
              g_r        <= '0;
              phase_r    <= mi4_pkg::PH_QUOT;
              state_r    <= S_DRD;
            end else if (last_grp) begin
              g_r     <= '0;
              phase_r <= (phase_r == mi4_pkg::PH_MINOR2) ? mi4_pkg::PH_COF
                                                         : mi4_pkg::PH_DET;
              state_r <= S_RD;
            end else begin
              g_r     <= g_r + 4'd1;
              state_r <= S_RD;
            end
          end
        end
        S_DRD: begin
          // Take the determinant magnitude once, before the first quotient
          if (g_r == '0) begin
            det_abs_r <= det_neg_r ? -det_abs_r : det_abs_r;
          end
          state_r <= S_DLAT;
        end
        S_DLAT: begin
          cneg_r <= b_rdata[mi4_pkg::ACC_W-1];
          if (det_zero_r) begin
            res_value_r <= '0;
            res_sing_r  <= 1'b1;
            res_sat_r   <= 1'b0;
            state_r     <= S_PUT;
          end else begin
            res_sing_r <= 1'b0;
            state_r    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            res_value_r <= quot_value;
            res_sat_r   <= quot_sat;
            state_r     <= S_PUT;
          end
        end
        S_PUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= res_value_r;
            out_index_r <= g_r;
            out_sing_r  <= res_sing_r;
            out_sat_r   <= res_sat_r;
            out_last_r  <= (g_r == 4'(mi4_pkg::LAST_INDEX));
            if (g_r == 4'(mi4_pkg::LAST_INDEX)) begin
              phase_r <= mi4_pkg::PH_MINOR2;
              g_r     <= '0;
              state_r <= S_LOAD;
            end else begin
              g_r     <= g_r + 4'd1;
              state_r <= S_DRD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/mi4_chk.sv -----
// Port-level checker for the matrix inverse, bound to the top level.
`include "matrix_inverse_4x4_defines.svh"

module mi4_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mi4_pkg::ELEM_W-1:0]  out_value,
  input logic [mi4_pkg::IDX_W-1:0]   out_index,
  input logic                        out_singular,
  input logic                        out_saturated,
  input logic                        out_last
);

  // Hold a stalled result beat
  `MI4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_index), "result beat changed while stalled")

  // Singular results are clean zeros
  `MI4_ASSERT_NOW(a_sing_zero, out_valid && out_singular, (out_value == '0) && !out_saturated, "singular result not zero")

  // Last flag marks the final index only
  `MI4_ASSERT_NOW(a_last_idx, out_valid, out_last == (out_index == 4'(mi4_pkg::LAST_INDEX)), "last flag out of place")

  // No loading while a matrix still has results to deliver
  `MI4_ASSERT_NOW(a_no_early_load, out_valid && !out_last, !in_ready, "input taken before results done")

endmodule

bind matrix_inverse_4x4 mi4_chk u_mi4_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_value     (out_ch.inverse_value),
  .out_index     (out_ch.element_index),
  .out_singular  (out_ch.singular),
  .out_saturated (out_ch.saturated),
  .out_last      (out_ch.last_of_matrix)
);
